@@ design/corexy_move_limit_checker_unit_macros.svh @@
// Assertion macros for the CoreXY move limit checker.
// Included by the top level; no other dependencies.
`ifndef COREXY_MOVE_LIMIT_CHECKER_UNIT_MACROS_SVH
`define COREXY_MOVE_LIMIT_CHECKER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define CMLC_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("cmlc assertion failed");
// Next-cycle implication, disabled during reset.
`define CMLC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("cmlc assertion failed");
`else
`define CMLC_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define CMLC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ design/cmlc_pkg.sv @@
// Shared types and constants for the CoreXY move limit checker.
// No dependencies; imported by every module of the block.
package cmlc_pkg;

    // Default depth of the queue between the front and back parts.
    localparam int CMLC_QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [2:0] REG_X_MIN       = 3'd0;
    localparam logic [2:0] REG_X_MAX       = 3'd1;
    localparam logic [2:0] REG_Y_MIN       = 3'd2;
    localparam logic [2:0] REG_Y_MAX       = 3'd3;
    localparam logic [2:0] REG_Z_MIN       = 3'd4;
    localparam logic [2:0] REG_Z_MAX       = 3'd5;
    localparam logic [2:0] REG_Z_VEL_CAP   = 3'd6;
    localparam logic [2:0] REG_Z_ACCEL_CAP = 3'd7;

    typedef enum logic [1:0] {
        OP_CHECK     = 2'd0,
        OP_HOME      = 2'd1,
        OP_MOTOR_OFF = 2'd2,
        OP_CLEAR_Z   = 2'd3
    } cmlc_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MUST_HOME = 2'd1,
        ST_ENDSTOP   = 2'd2
    } cmlc_status_t;

    // One input item.
    typedef struct packed {
        cmlc_op_t           operation;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
        logic [31:0]        move_distance;
        logic [2:0]         home_mask;
    } cmlc_cmd_t;

    // One result item.
    typedef struct packed {
        cmlc_status_t status;
        logic         speed_limited;
        logic [31:0]  velocity_limit;
        logic [31:0]  accel_limit;
        logic [2:0]   homed_flags;
    } cmlc_result_t;

    // Rail ranges used by the front part.
    typedef struct packed {
        logic signed [31:0] x_min;
        logic signed [31:0] x_max;
        logic signed [31:0] y_min;
        logic signed [31:0] y_max;
        logic signed [31:0] z_min;
        logic signed [31:0] z_max;
    } cmlc_limits_t;

    // Z caps used by the back part.
    typedef struct packed {
        logic [31:0] vel;
        logic [31:0] accel;
    } cmlc_caps_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        cmlc_status_t status;
        logic         divide;
        logic [2:0]   homed;
        logic [31:0]  move_len;
        logic [31:0]  dz_abs;
    } cmlc_job_t;

    // Queue status seen by both parts.
    typedef struct packed {
        logic empty;
        logic full;
    } cmlc_qstat_t;

endpackage

@@ design/cmlc_front.sv @@
// Front part: accepts items, keeps the homed flags and checks the rails.
// Depends on cmlc_pkg.
module cmlc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  cmlc_pkg::cmlc_cmd_t     cmd,
    input  cmlc_pkg::cmlc_limits_t  limits,
    input  cmlc_pkg::cmlc_qstat_t   qstat,
    output logic                    job_valid,
    output cmlc_pkg::cmlc_job_t     job
);
    import cmlc_pkg::*;

    logic [2:0]         homed_reg;
    logic [2:0]         homed_next;
    logic               accept;
    cmlc_status_t       chk_status;
    logic signed [31:0] end_p [3];
    logic signed [31:0] delta [3];
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];

    assign full   = qstat.full;
    assign accept = push && !qstat.full;

    assign end_p[0] = cmd.end_x;
    assign end_p[1] = cmd.end_y;
    assign end_p[2] = cmd.end_z;
    assign delta[0] = cmd.delta_x;
    assign delta[1] = cmd.delta_y;
    assign delta[2] = cmd.delta_z;
    assign lo[0]    = limits.x_min;
    assign lo[1]    = limits.y_min;
    assign lo[2]    = limits.z_min;
    assign hi[0]    = limits.x_max;
    assign hi[1]    = limits.y_max;
    assign hi[2]    = limits.z_max;

    // The first moving axis that faults decides: unhomed, or homed with its end off the rail.
    always_comb
    begin
        logic hit;
        hit        = 1'b0;
        chk_status = ST_OK;
        for (int i = 0; i < 3; i++)
        begin
            if (!hit && delta[i] != 32'sd0)
            begin
                hit = 1'b1;
                if (!homed_reg[i])
                begin
                    chk_status = ST_MUST_HOME;
                end
                else if (end_p[i] < lo[i] || end_p[i] > hi[i])
                begin
                    chk_status = ST_ENDSTOP;
                end
                else
                begin
                    hit = 1'b0;
                end
            end
        end
    end

    // Homed flags after this item.
    always_comb
    begin
        case (cmd.operation)
            OP_HOME:      homed_next = homed_reg | cmd.home_mask;
            OP_MOTOR_OFF: homed_next = 3'b000;
            OP_CLEAR_Z:   homed_next = homed_reg & 3'b011;
            default:      homed_next = homed_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            homed_reg <= 3'b000;
        end
        else if (accept)
        begin
            homed_reg <= homed_next;
        end
    end

    // Classified item for the queue.
    always_comb
    begin
        job_valid     = accept;
        job.status    = (cmd.operation == OP_CHECK) ? chk_status : ST_OK;
        job.divide    = (cmd.operation == OP_CHECK) && (chk_status == ST_OK)
                        && (cmd.delta_z != 32'sd0);
        job.homed     = homed_next;
        job.move_len  = cmd.move_distance;
        job.dz_abs    = cmd.delta_z[31] ? (~cmd.delta_z + 32'd1) : cmd.delta_z;
    end

endmodule

@@ design/cmlc_queue.sv @@
// Short queue of classified items between the front and back parts.
// Depends on cmlc_pkg.
module cmlc_queue #(
    parameter int DEPTH = cmlc_pkg::CMLC_QUEUE_DEPTH  // 2 or more
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  cmlc_pkg::cmlc_job_t   wr_data,
    input  logic                  rd_en,
    output cmlc_pkg::cmlc_job_t   rd_data,
    output cmlc_pkg::cmlc_qstat_t qstat
);
    import cmlc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmlc_job_t     entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CW'(DEPTH));
    assign do_wr       = wr_en && !qstat.full;
    assign do_rd       = rd_en && !qstat.empty;
    assign rd_data     = entries_reg[rd_ptr_reg];

    // Pointers wrap at the depth, which need not be a power of two.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/cmlc_back.sv @@
// Back part: scales the z caps by distance over |dz| and holds the result item.
// Depends on cmlc_pkg.
module cmlc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmlc_pkg::cmlc_qstat_t qstat,
    input  cmlc_pkg::cmlc_job_t   job,
    output logic                  job_take,
    input  cmlc_pkg::cmlc_caps_t  caps,
    output logic                  empty,
    input  logic                  pop,
    output cmlc_pkg::cmlc_result_t result
);
    import cmlc_pkg::*;

    // Two quotient bits per cycle over a 32-bit quotient.
    localparam int DIV_CYCLES = 16;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MULV = 4'b0010,
        B_MULA = 4'b0100,
        B_DIV  = 4'b1000
    } cmlc_back_state_t;

    cmlc_back_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    cmlc_result_t     out_reg, out_next;
    cmlc_status_t     status_reg, status_next;
    logic [2:0]       homed_reg, homed_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      dz_reg, dz_next;
    logic [63:0]      rq_v_reg, rq_v_next;
    logic [63:0]      rq_a_reg, rq_a_next;
    logic             sat_v_reg, sat_v_next;
    logic             sat_a_reg, sat_a_next;
    logic [31:0]      mul_a;
    logic [63:0]      prod;
    logic [63:0]      step_v;
    logic [63:0]      step_a;
    logic             pop_ok;
    logic             out_free;

    // One restoring division step: remainder in the upper half, dividend and
    // quotient bits sharing the lower half.
    function automatic logic [63:0] div_step(input logic [63:0] rq, input logic [31:0] d);
        logic [32:0] r;
        logic        q;
        r = {rq[63:32], rq[31]};
        q = (r >= {1'b0, d});
        if (q)
        begin
            r = r - {1'b0, d};
        end
        return {r[31:0], rq[30:0], q};
    endfunction

    assign pop_ok   = pop && out_valid_reg;
    assign out_free = !out_valid_reg || pop_ok;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    // One shared multiplier, velocity cap first, then acceleration cap.
    assign mul_a  = (state_reg == B_MULV) ? caps.vel : caps.accel;
    assign prod   = {32'd0, mul_a} * {32'd0, len_reg};
    assign step_v = div_step(div_step(rq_v_reg, dz_reg), dz_reg);
    assign step_a = div_step(div_step(rq_a_reg, dz_reg), dz_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        status_next    = status_reg;
        homed_next     = homed_reg;
        len_next       = len_reg;
        dz_next        = dz_reg;
        rq_v_next      = rq_v_reg;
        rq_a_next      = rq_a_reg;
        sat_v_next     = sat_v_reg;
        sat_a_next     = sat_a_reg;
        job_take       = 1'b0;

        if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                // Take the next item once the result register is free.
                if (!qstat.empty && out_free)
                begin
                    job_take = 1'b1;
                    if (job.divide)
                    begin
                        status_next = job.status;
                        homed_next  = job.homed;
                        len_next    = job.move_len;
                        dz_next     = job.dz_abs;
                        state_next  = B_MULV;
                    end
                    else
                    begin
                        out_next.status         = job.status;
                        out_next.speed_limited  = 1'b0;
                        out_next.velocity_limit = 32'd0;
                        out_next.accel_limit    = 32'd0;
                        out_next.homed_flags    = job.homed;
                        out_valid_next          = 1'b1;
                    end
                end
            end
            B_MULV:
            begin
                rq_v_next  = prod;
                state_next = B_MULA;
            end
            B_MULA:
            begin
                rq_a_next  = prod;
                cnt_next   = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                // A quotient above 32 bits shows as a high half at or above |dz|.
                if (cnt_reg == '0)
                begin
                    sat_v_next = (rq_v_reg[63:32] >= dz_reg);
                    sat_a_next = (rq_a_reg[63:32] >= dz_reg);
                end
                rq_v_next = step_v;
                rq_a_next = step_a;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
                begin
                    out_next.status         = status_reg;
                    out_next.speed_limited  = 1'b1;
                    out_next.velocity_limit = sat_v_reg ? 32'hFFFF_FFFF : step_v[31:0];
                    out_next.accel_limit    = sat_a_reg ? 32'hFFFF_FFFF : step_a[31:0];
                    out_next.homed_flags    = homed_reg;
                    out_valid_next          = 1'b1;
                    state_next              = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry payload only.
    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        status_reg <= status_next;
        homed_reg  <= homed_next;
        len_reg    <= len_next;
        dz_reg     <= dz_next;
        rq_v_reg   <= rq_v_next;
        rq_a_reg   <= rq_a_next;
        sat_v_reg  <= sat_v_next;
        sat_a_reg  <= sat_a_next;
    end

endmodule

@@ design/corexy_move_limit_checker_unit.sv @@
// CoreXY move limit checker. Keeps the x, y and z homed flags, checks each
// move against the configured rail ranges and scales the z velocity and
// acceleration caps by move distance over |delta_z|, saturating at all ones.
// Every item yields one result item, in order. The front part takes an item
// in the cycle it is pushed unless the queue is full. The back part hands an
// item without z scaling straight to the result register; a checked move with
// z travel goes through the shared 32x32 multiplier for both caps in turn,
// then a two-bit-per-cycle divider that serves both limits side by side.
// A queue of QUEUE_DEPTH items and the result register sit between the sides,
// so pushes continue while a result waits to be popped. Configuration writes
// take effect on the next clock and are meant for when the block is idle.
// Depends on cmlc_pkg, cmlc_front, cmlc_queue, cmlc_back and the macro header.
`include "corexy_move_limit_checker_unit_macros.svh"

module corexy_move_limit_checker_unit #(
    parameter int QUEUE_DEPTH = cmlc_pkg::CMLC_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  cmlc_pkg::cmlc_cmd_t    cmd,
    output logic                   empty,
    input  logic                   pop,
    output cmlc_pkg::cmlc_result_t result,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data
);
    import cmlc_pkg::*;

    cmlc_limits_t limits_reg;
    cmlc_caps_t   caps_reg;
    cmlc_qstat_t  qstat;
    cmlc_job_t    wr_job;
    cmlc_job_t    rd_job;
    logic         wr_en;
    logic         rd_en;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg <= '0;
            caps_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_MIN:       limits_reg.x_min <= cfg_data;
                REG_X_MAX:       limits_reg.x_max <= cfg_data;
                REG_Y_MIN:       limits_reg.y_min <= cfg_data;
                REG_Y_MAX:       limits_reg.y_max <= cfg_data;
                REG_Z_MIN:       limits_reg.z_min <= cfg_data;
                REG_Z_MAX:       limits_reg.z_max <= cfg_data;
                REG_Z_VEL_CAP:   caps_reg.vel     <= cfg_data;
                REG_Z_ACCEL_CAP: caps_reg.accel   <= cfg_data;
                default:         limits_reg       <= limits_reg;
            endcase
        end
    end

    cmlc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .limits    (limits_reg),
        .qstat     (qstat),
        .job_valid (wr_en),
        .job       (wr_job)
    );

    cmlc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_job),
        .rd_en   (rd_en),
        .rd_data (rd_job),
        .qstat   (qstat)
    );

    cmlc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .job      (rd_job),
        .job_take (rd_en),
        .caps     (caps_reg),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // A result without z scaling carries zero limits.
    `CMLC_ASSERT_IMPLIES(a_unlimited_zero, clk, rst_n,
        !empty && !result.speed_limited,
        result.velocity_limit == 32'd0 && result.accel_limit == 32'd0)
    // Only a move that passed the check is scaled.
    `CMLC_ASSERT_IMPLIES(a_limited_ok, clk, rst_n,
        !empty && result.speed_limited, result.status == ST_OK)
    // The back part never takes an item from an empty queue.
    `CMLC_ASSERT_IMPLIES(a_take_nonempty, clk, rst_n, rd_en, !qstat.empty)

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the CoreXY move limit checker (corexy_move_limit_checker_unit).
// It predicts each result item from its own copy of the homed flags and the rail registers.
// Depends only on cmlc_pkg and the block under test.
`timescale 1ns / 100ps

module tb_top;
    import cmlc_pkg::*;

    // Block interface.
    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         push = 1'b0;
    logic         full;
    cmlc_cmd_t    cmd = '0;
    logic         empty;
    logic         pop = 1'b0;
    cmlc_result_t result;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = REG_X_MIN;
    logic [31:0]  cfg_data = '0;

    // Predictor state: homed flags, rail ranges per axis and the two z caps.
    logic [2:0]         homed_model = '0;
    logic signed [31:0] rail_lo [3] = '{default: '0};
    logic signed [31:0] rail_hi [3] = '{default: '0};
    logic [31:0]        z_vel_cap = '0;
    logic [31:0]        z_accel_cap = '0;

    // Results still owed by the block, oldest first.
    cmlc_result_t pending_results [$];

    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold_left = 0;

    corexy_move_limit_checker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(5_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

    // Limit = floor(cap * distance / |dz|), saturating at all ones.
    function automatic logic [31:0] scale_cap(input logic [31:0] cap, input logic [31:0] move_len,
                                              input logic [63:0] dz_mag);
        logic [63:0] quotient;
        quotient = ({32'd0, cap} * {32'd0, move_len}) / dz_mag;
        return (quotient > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : quotient[31:0];
    endfunction

    // Works out the result of one accepted item and updates the homed flags.
    function automatic cmlc_result_t predict_move_result(input cmlc_cmd_t c);
        cmlc_result_t       r;
        logic signed [31:0] end_pos [3];
        logic signed [31:0] travel [3];
        longint             dz;
        logic [63:0]        dz_mag;
        r = '0;
        r.status = ST_OK;
        case (c.operation)
            OP_HOME:      homed_model = homed_model | c.home_mask;
            OP_MOTOR_OFF: homed_model = '0;
            OP_CLEAR_Z:   homed_model[2] = 1'b0;
            default:
            begin
                end_pos = '{c.end_x, c.end_y, c.end_z};
                travel = '{c.delta_x, c.delta_y, c.delta_z};
                // Axes with travel are checked in x, y, z order; the first fault wins.
                for (int i = 0; i < 3; i++)
                begin
                    if (travel[i] != 0 && r.status == ST_OK)
                    begin
                        if (!homed_model[i])
                            r.status = ST_MUST_HOME;
                        else if (end_pos[i] < rail_lo[i] || end_pos[i] > rail_hi[i])
                            r.status = ST_ENDSTOP;
                    end
                end
                // A clean move with z travel gets scaled z limits.
                if (r.status == ST_OK && c.delta_z != 0)
                begin
                    dz = longint'($signed(c.delta_z));
                    dz_mag = (dz < 0) ? -dz : dz;
                    r.speed_limited = 1'b1;
                    r.velocity_limit = scale_cap(z_vel_cap, c.move_distance, dz_mag);
                    r.accel_limit = scale_cap(z_accel_cap, c.move_distance, dz_mag);
                end
            end
        endcase
        r.homed_flags = homed_model;
        return r;
    endfunction

    function automatic void note_failure(input string what, input logic [31:0] want_v,
                                         input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("tb_top: mismatch in %s at %0t: expected %h, got %h",
                     what, $time, want_v, got_v);
    endfunction

    // Compares one popped result item with the oldest prediction.
    function automatic void check_result(input cmlc_result_t got);
        cmlc_result_t want;
        if (pending_results.size() == 0)
        begin
            note_failure("unexpected result", '0, got.homed_flags);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            note_failure("status", want.status, got.status);
        if (got.speed_limited !== want.speed_limited)
            note_failure("speed_limited", want.speed_limited, got.speed_limited);
        if (got.velocity_limit !== want.velocity_limit)
            note_failure("velocity_limit", want.velocity_limit, got.velocity_limit);
        if (got.accel_limit !== want.accel_limit)
            note_failure("accel_limit", want.accel_limit, got.accel_limit);
        if (got.homed_flags !== want.homed_flags)
            note_failure("homed_flags", want.homed_flags, got.homed_flags);
    endfunction

    // Result side: checks each popped item, then decides whether to pop next cycle.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                check_result(result);
            if (recv_hold_left > 0)
            begin
                pop <= 1'b0;
                recv_hold_left--;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one item after a random gap and waits until the block takes it.
    // Push stays high afterwards so back-to-back items need no extra edge.
    task automatic send_item(input cmlc_cmd_t c);
        cmlc_result_t expected;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected = predict_move_result(c);
        pending_results.insert(pending_results.size(), expected);
    endtask

    // Stops sending and waits until every result item has been popped.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Writes all eight registers while the block is idle.
    task automatic load_config(input logic [31:0] x_lo, input logic [31:0] x_hi,
                               input logic [31:0] y_lo, input logic [31:0] y_hi,
                               input logic [31:0] z_lo, input logic [31:0] z_hi,
                               input logic [31:0] vel_cap, input logic [31:0] accel_cap);
        cfg_write(REG_X_MIN, x_lo);
        cfg_write(REG_X_MAX, x_hi);
        cfg_write(REG_Y_MIN, y_lo);
        cfg_write(REG_Y_MAX, y_hi);
        cfg_write(REG_Z_MIN, z_lo);
        cfg_write(REG_Z_MAX, z_hi);
        cfg_write(REG_Z_VEL_CAP, vel_cap);
        cfg_write(REG_Z_ACCEL_CAP, accel_cap);
        cfg_we <= 1'b0;
        @(posedge clk);
        rail_lo = '{x_lo, y_lo, z_lo};
        rail_hi = '{x_hi, y_hi, z_hi};
        z_vel_cap = vel_cap;
        z_accel_cap = accel_cap;
    endtask

    function automatic cmlc_cmd_t make_cmd(input cmlc_op_t op,
                                           input logic [31:0] ex, input logic [31:0] ey,
                                           input logic [31:0] ez, input logic [31:0] dx,
                                           input logic [31:0] dy, input logic [31:0] dz,
                                           input logic [31:0] move_len, input logic [2:0] mask);
        cmlc_cmd_t c;
        c.operation = op;
        c.end_x = ex;
        c.end_y = ey;
        c.end_z = ez;
        c.delta_x = dx;
        c.delta_y = dy;
        c.delta_z = dz;
        c.move_distance = move_len;
        c.home_mask = mask;
        return c;
    endfunction

    // End position: mostly inside a valid rail range, sometimes at an edge or anywhere.
    function automatic logic [31:0] pick_end(input logic signed [31:0] lo,
                                             input logic signed [31:0] hi);
        longint unsigned span;
        longint unsigned offset;
        int unsigned     pick;
        pick = $urandom_range(99);
        if (lo > hi || pick >= 85)
            return $urandom;
        if (pick < 8)
            return lo;
        if (pick < 16)
            return hi;
        span = longint'(hi) - longint'(lo) + 1;
        offset = {$urandom, $urandom} % span;
        return 32'(longint'(lo) + longint'(offset));
    endfunction

    // Travel: zero, short, or anything in the 32-bit range.
    function automatic logic [31:0] pick_travel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return '0;
        if (pick < 65)
            return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
        return $urandom;
    endfunction

    function automatic cmlc_cmd_t random_cmd();
        cmlc_cmd_t   c;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 72)
            c.operation = OP_CHECK;
        else if (pick < 86)
            c.operation = OP_HOME;
        else if (pick < 93)
            c.operation = OP_MOTOR_OFF;
        else
            c.operation = OP_CLEAR_Z;
        c.end_x = pick_end(rail_lo[0], rail_hi[0]);
        c.end_y = pick_end(rail_lo[1], rail_hi[1]);
        c.end_z = pick_end(rail_lo[2], rail_hi[2]);
        c.delta_x = pick_travel();
        c.delta_y = pick_travel();
        c.delta_z = pick_travel();
        c.move_distance = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0100_0000);
        c.home_mask = ($urandom_range(2) == 0) ? 3'($urandom_range(7)) : 3'b111;
        return c;
    endfunction

    // One rail pair: full range, inverted, or an ordinary random range.
    task automatic pick_rail(output logic [31:0] lo, output logic [31:0] hi);
        int unsigned      pick;
        logic signed [31:0] a;
        logic signed [31:0] b;
        pick = $urandom_range(99);
        a = $urandom;
        b = $urandom;
        if (pick < 10)
        begin
            lo = 32'h8000_0000;
            hi = 32'h7FFF_FFFF;
        end
        else if (pick < 18)
        begin
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
        end
        else
        begin
            lo = (a > b) ? b : a;
            hi = (a > b) ? a : b;
        end
    endtask

    function automatic logic [31:0] pick_cap();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic load_random_config();
        logic [31:0] xl, xh, yl, yh, zl, zh;
        pick_rail(xl, xh);
        pick_rail(yl, yh);
        pick_rail(zl, zh);
        load_config(xl, xh, yl, yh, zl, zh, pick_cap(), pick_cap());
    endtask

    // Directed items: every operation, field extremes and the corner cases.
    task automatic test_directed();
        send_idle_pct = 18;
        recv_idle_pct = 66;
        // Rails of +/-100 mm on x and y, 0..200 mm on z.
        load_config(32'hFF9C_0000, 32'h0064_0000, 32'hFF9C_0000, 32'h0064_0000,
                    32'h0000_0000, 32'h00C8_0000, 32'hFFFF_FFFF, 32'h0001_0000);
        // Travel on an unhomed axis.
        send_item(make_cmd(OP_CHECK, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 3'b000));
        // Homing with an empty mask leaves the flags alone.
        send_item(make_cmd(OP_HOME, 0, 0, 0, 0, 0, 0, 0, 3'b000));
        send_item(make_cmd(OP_HOME, 0, 0, 0, 0, 0, 0, 0, 3'b001));
        // x is homed now, y is not.
        send_item(make_cmd(OP_CHECK, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 3'b000));
        send_item(make_cmd(OP_HOME, 0, 0, 0, 0, 0, 0, 0, 3'b110));
        // Ends on the rail edges; the smallest |dz| saturates both limits.
        send_item(make_cmd(OP_CHECK, 32'h0064_0000, 32'hFF9C_0000, 0, 1, 1, 1,
                           32'hFFFF_FFFF, 3'b000));
        // The most negative dz.
        send_item(make_cmd(OP_CHECK, 0, 0, 32'h0010_0000, 0, 0, 32'h8000_0000,
                           32'hFFFF_FFFF, 3'b000));
        // Zero move distance with z travel.
        send_item(make_cmd(OP_CHECK, 0, 0, 32'h00C8_0000, 0, 0, 32'h7FFF_FFFF, 0, 3'b000));
        // No z travel, so no limits.
        send_item(make_cmd(OP_CHECK, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 0, 0,
                           32'h0001_0000, 3'b000));
        // Just past x max.
        send_item(make_cmd(OP_CHECK, 32'h0064_0001, 0, 0, 32'h0001_0000, 0, 0, 0, 3'b000));
        // An out-of-range end is ignored on an axis without travel.
        send_item(make_cmd(OP_CHECK, 32'h7FFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 3'b000));
        // Just below z min.
        send_item(make_cmd(OP_CHECK, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'h0002_0000,
                           32'h0005_0000, 3'b000));
        send_item(make_cmd(OP_CLEAR_Z, 0, 0, 0, 0, 0, 0, 0, 3'b111));
        send_item(make_cmd(OP_CHECK, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000,
                           32'h0001_0000, 3'b000));
        send_item(make_cmd(OP_MOTOR_OFF, 0, 0, 0, 0, 0, 0, 0, 3'b111));
        // No travel at all passes even with nothing homed.
        send_item(make_cmd(OP_CHECK, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                           32'hFFFF_FFFF, 3'b000));
        wait_idle();

        // Full-range rails and zero caps.
        load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_item(make_cmd(OP_HOME, 0, 0, 0, 0, 0, 0, 0, 3'b111));
        send_item(make_cmd(OP_CHECK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 3'b111));
        send_item(make_cmd(OP_CHECK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                           32'hFFFF_FFFF, 3'b000));
        wait_idle();

        // Inverted y range: any y travel hits the endstop.
        load_config(32'hFF9C_0000, 32'h0064_0000, 32'h0001_0000, 32'hFFFF_0000,
                    32'h0000_0000, 32'h00C8_0000, 32'h1234_5678, 32'h8765_4321);
        send_item(make_cmd(OP_CHECK, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 3'b000));
        send_item(make_cmd(OP_CHECK, 0, 0, 32'h0003_0000, 32'h0001_0000, 0, 32'h0003_0000,
                           32'h0004_0000, 3'b000));
        wait_idle();
    endtask

    // Random items in three register settings with the given idling mix.
    task automatic test_random(input int items, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int phase = 0; phase < 3; phase++)
        begin
            load_random_config();
            // Start each setting from a homed machine so checks get deep.
            send_item(make_cmd(OP_HOME, 0, 0, 0, 0, 0, 0, 0, 3'b111));
            for (int n = 0; n < items / 3; n++)
                send_item(random_cmd());
            wait_idle();
        end
    endtask

    // Result side stalls for a long stretch while items keep coming, so full must rise.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_random_config();
        recv_hold_left = 300;
        for (int n = 0; n < 60; n++)
            send_item(random_cmd());
        wait_idle();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600, 18, 66);
        test_random(600, 66, 18);
        test_backpressure();
        test_random(600, 0, 0);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
